// ===== rtl/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfd_pkg: shared definitions for the crc32 frame deframer
// Register indexes, work codes passed from front to back, and CRC-32 helpers.
// ----------------------------------------------------------------------------
package cfd_pkg;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // crc-32/ieee, reflected
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

   // configuration register indexes
   localparam logic [2:0] CSR_FRAME_MAGIC   = 3'd0;
   localparam logic [2:0] CSR_PROTO_VERSION = 3'd1;
   localparam logic [2:0] CSR_REQUEST_TYPE  = 3'd2;
   localparam logic [2:0] CSR_RESPONSE_TYPE = 3'd3;
   localparam logic [2:0] CSR_HEARTBEAT     = 3'd4;

   // register reset values
   localparam logic [31:0] RST_FRAME_MAGIC   = 32'h0000_0000;
   localparam logic [7:0]  RST_PROTO_VERSION = 8'h01;
   localparam logic [7:0]  RST_REQUEST_TYPE  = 8'h00;
   localparam logic [7:0]  RST_RESPONSE_TYPE = 8'h01;
   localparam logic [7:0]  RST_HEARTBEAT     = 8'h02;

   // verdict codes
   localparam logic [1:0] VERDICT_GOOD     = 2'd0;
   localparam logic [1:0] VERDICT_CRC_BAD  = 2'd1;
   localparam logic [1:0] VERDICT_TYPE_BAD = 2'd2;

   // record kinds
   localparam logic KIND_BODY    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // what the back end does with a queued byte
   typedef enum logic [2:0] {
      OP_START    = 3'd0,
      OP_TYPE     = 3'd1,
      OP_LEN_HI   = 3'd2,
      OP_LEN_LO   = 3'd3,
      OP_ID       = 3'd4,
      OP_BODY     = 3'd5,
      OP_CHK      = 3'd6,
      OP_CHK_LAST = 3'd7
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } work_type;

   typedef struct packed {
      logic [31:0] magic;
      logic [7:0]  version;
   } front_cfg_type;

   typedef struct packed {
      logic [31:0] magic_crc;
      logic [7:0]  request_type;
      logic [7:0]  response_type;
      logic [7:0]  heartbeat_type;
   } back_cfg_type;

   // one entry of the byte-wise crc table
   function automatic logic [31:0] crc_table(input logic [7:0] idx);
      logic [31:0] c;
      c = {24'd0, idx};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // feed one byte into the running crc
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      return (crc >> 8) ^ crc_table(crc[7:0] ^ b);
   endfunction

endpackage

// ===== rtl/cfd_if.sv =====
// ----------------------------------------------------------------------------
// cfd_if: stream channels of the crc32 frame deframer
// Byte input channel and record output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface cfd_rsp_if;
   logic        valid;
   logic        ready;
   logic        record_kind;
   logic [7:0]  body_byte;
   logic [7:0]  message_type;
   logic [63:0] request_id;
   logic [15:0] body_length;
   logic [1:0]  verdict;
   logic        last_of_frame;

   modport source (output valid, output record_kind, output body_byte, output message_type,
                   output request_id, output body_length, output verdict,
                   output last_of_frame, input ready);
   modport sink   (input valid, input record_kind, input body_byte, input message_type,
                   input request_id, input body_length, input verdict,
                   input last_of_frame, output ready);
endinterface

// ===== rtl/cfd_front.sv =====
// ----------------------------------------------------------------------------
// cfd_front: frame hunter and byte classifier
// Tracks the frame position of every received word and tags it with the
// work the back end must do; hunt bytes that do not start a frame are dropped.
// ----------------------------------------------------------------------------
module cfd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  cfd_pkg::front_cfg_type cfg,
   cfd_req_if.sink                req_chan,
   input  logic                   q_not_full,
   output logic                   push,
   output cfd_pkg::work_type      push_work
);

   typedef enum logic [3:0] {
      ST_HUNT   = 4'b0001,
      ST_HEADER = 4'b0010,
      ST_BODY   = 4'b0100,
      ST_CHECK  = 4'b1000
   } fstate_type;

   fstate_type  state_ff, state_in;
   logic [31:0] recent_ff, recent_in;
   logic [2:0]  fill_ff, fill_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [15:0] len_ff, len_in;
   logic        accept;
   logic [7:0]  b;
   logic [15:0] cnt_inc;

   assign req_chan.ready = q_not_full;
   assign accept  = req_chan.valid && q_not_full;
   assign b       = req_chan.in_byte;
   assign cnt_inc = cnt_ff + 16'd1;

   // phase tracking and tagging
   always_comb begin
      state_in  = state_ff;
      recent_in = recent_ff;
      fill_in   = fill_ff;
      cnt_in    = cnt_ff;
      len_in    = len_ff;
      push      = 1'b0;
      push_work = '{op: cfd_pkg::OP_BODY, data: b};
      if (accept) begin
         case (state_ff)
            ST_HUNT: begin
               if (fill_ff == 3'd4 && recent_ff == cfg.magic && b == cfg.version) begin
                  push           = 1'b1;
                  push_work.op   = cfd_pkg::OP_START;
                  state_in       = ST_HEADER;
                  cnt_in         = 16'd0;
                  recent_in      = 32'd0;
                  fill_in        = 3'd0;
               end else begin
                  recent_in = {recent_ff[23:0], b};
                  if (fill_ff != 3'd4) begin
                     fill_in = fill_ff + 3'd1;
                  end
               end
            end
            ST_HEADER: begin
               push = 1'b1;
               if (cnt_ff == 16'd0) begin
                  push_work.op = cfd_pkg::OP_TYPE;
               end else if (cnt_ff == 16'd1) begin
                  push_work.op = cfd_pkg::OP_LEN_HI;
                  len_in       = {b, 8'd0};
               end else if (cnt_ff == 16'd2) begin
                  push_work.op = cfd_pkg::OP_LEN_LO;
                  len_in       = {len_ff[15:8], b};
               end else begin
                  push_work.op = cfd_pkg::OP_ID;
               end
               if (cnt_ff == 16'd10) begin
                  cnt_in   = 16'd0;
                  state_in = (len_ff != 16'd0) ? ST_BODY : ST_CHECK;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            ST_BODY: begin
               push         = 1'b1;
               push_work.op = cfd_pkg::OP_BODY;
               if (cnt_inc == len_ff) begin
                  cnt_in   = 16'd0;
                  state_in = ST_CHECK;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            ST_CHECK: begin
               push = 1'b1;
               if (cnt_ff == 16'd3) begin
                  push_work.op = cfd_pkg::OP_CHK_LAST;
                  state_in     = ST_HUNT;
                  cnt_in       = 16'd0;
                  recent_in    = 32'd0;
                  fill_in      = 3'd0;
               end else begin
                  push_work.op = cfd_pkg::OP_CHK;
                  cnt_in       = cnt_inc;
               end
            end
            default: begin
               state_in = ST_HUNT;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_HUNT;
         recent_ff <= 32'd0;
         fill_ff   <= 3'd0;
         cnt_ff    <= 16'd0;
         len_ff    <= 16'd0;
      end else begin
         state_ff  <= state_in;
         recent_ff <= recent_in;
         fill_ff   <= fill_in;
         cnt_ff    <= cnt_in;
         len_ff    <= len_in;
      end
   end

endmodule

// ===== rtl/cfd_queue.sv =====
// ----------------------------------------------------------------------------
// cfd_queue: short work queue between front and back
// Flop-based fifo so that the hunter and the record builder stall apart.
// ----------------------------------------------------------------------------
module cfd_queue #(
   parameter int Depth = cfd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cfd_pkg::work_type push_work,
   input  logic              pop,
   output logic              not_full,
   output logic              not_empty,
   output cfd_pkg::work_type head
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

   cfd_pkg::work_type     mem_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;

   assign not_full  = (cnt_ff != FullCnt);
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_work;
      end
   end

endmodule

// ===== rtl/cfd_back.sv =====
// ----------------------------------------------------------------------------
// cfd_back: crc engine and record builder
// Runs one crc table step per queued header or body word, captures the header
// fields and drives body and verdict records through a registered output stage.
// ----------------------------------------------------------------------------
module cfd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  cfd_pkg::back_cfg_type cfg,
   input  logic                  q_not_empty,
   input  cfd_pkg::work_type     head,
   output logic                  pop,
   cfd_rsp_if.source             rsp_chan
);

   logic [31:0] crc_ff, crc_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] len_ff, len_in;
   logic [63:0] id_ff, id_in;
   logic [23:0] chk_ff, chk_in;

   logic        valid_ff, valid_in;
   logic        kind_ff, kind_in;
   logic [7:0]  body_ff, body_in;
   logic [7:0]  mtype_ff, mtype_in;
   logic [63:0] rid_ff, rid_in;
   logic [15:0] blen_ff, blen_in;
   logic [1:0]  verdict_ff, verdict_in;
   logic        last_ff, last_in;

   logic        needs_out;
   logic        slot_free;
   logic [31:0] crc_step;
   logic [31:0] rx_crc;
   logic        type_known;

   assign needs_out  = (head.op == cfd_pkg::OP_BODY) || (head.op == cfd_pkg::OP_CHK_LAST);
   assign slot_free  = !valid_ff || rsp_chan.ready;
   assign pop        = q_not_empty && (!needs_out || slot_free);
   assign crc_step   = cfd_pkg::crc_byte(crc_ff, head.data);
   assign rx_crc     = {chk_ff, head.data};
   assign type_known = (type_ff == cfg.request_type) || (type_ff == cfg.response_type) ||
                       (type_ff == cfg.heartbeat_type);

   // work execution
   always_comb begin
      crc_in     = crc_ff;
      type_in    = type_ff;
      len_in     = len_ff;
      id_in      = id_ff;
      chk_in     = chk_ff;
      valid_in   = valid_ff && !rsp_chan.ready;
      kind_in    = kind_ff;
      body_in    = body_ff;
      mtype_in   = mtype_ff;
      rid_in     = rid_ff;
      blen_in    = blen_ff;
      verdict_in = verdict_ff;
      last_in    = last_ff;
      if (pop) begin
         case (head.op)
            cfd_pkg::OP_START: begin
               crc_in = cfd_pkg::crc_byte(cfg.magic_crc, head.data);
            end
            cfd_pkg::OP_TYPE: begin
               crc_in  = crc_step;
               type_in = head.data;
            end
            cfd_pkg::OP_LEN_HI: begin
               crc_in = crc_step;
               len_in = {head.data, 8'd0};
            end
            cfd_pkg::OP_LEN_LO: begin
               crc_in = crc_step;
               len_in = {len_ff[15:8], head.data};
            end
            cfd_pkg::OP_ID: begin
               crc_in = crc_step;
               id_in  = {id_ff[55:0], head.data};
            end
            cfd_pkg::OP_BODY: begin
               crc_in     = crc_step;
               valid_in   = 1'b1;
               kind_in    = cfd_pkg::KIND_BODY;
               body_in    = head.data;
               mtype_in   = type_ff;
               rid_in     = id_ff;
               blen_in    = len_ff;
               verdict_in = cfd_pkg::VERDICT_GOOD;
               last_in    = 1'b0;
            end
            cfd_pkg::OP_CHK: begin
               chk_in = {chk_ff[15:0], head.data};
            end
            cfd_pkg::OP_CHK_LAST: begin
               crc_in   = cfd_pkg::CRC_ONES;
               valid_in = 1'b1;
               kind_in  = cfd_pkg::KIND_VERDICT;
               body_in  = 8'd0;
               mtype_in = type_ff;
               rid_in   = id_ff;
               blen_in  = len_ff;
               last_in  = 1'b1;
               // crc checked before type
               if ((crc_ff ^ cfd_pkg::CRC_ONES) != rx_crc) begin
                  verdict_in = cfd_pkg::VERDICT_CRC_BAD;
               end else if (type_known) begin
                  verdict_in = cfd_pkg::VERDICT_GOOD;
               end else begin
                  verdict_in = cfd_pkg::VERDICT_TYPE_BAD;
               end
            end
            default: begin
               crc_in = crc_ff;
            end
         endcase
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         crc_ff   <= cfd_pkg::CRC_ONES;
      end else begin
         valid_ff <= valid_in;
         crc_ff   <= crc_in;
      end
   end

   // header fields and output word
   always_ff @(posedge clock) begin
      type_ff    <= type_in;
      len_ff     <= len_in;
      id_ff      <= id_in;
      chk_ff     <= chk_in;
      kind_ff    <= kind_in;
      body_ff    <= body_in;
      mtype_ff   <= mtype_in;
      rid_ff     <= rid_in;
      blen_ff    <= blen_in;
      verdict_ff <= verdict_in;
      last_ff    <= last_in;
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.record_kind   = kind_ff;
   assign rsp_chan.body_byte     = body_ff;
   assign rsp_chan.message_type  = mtype_ff;
   assign rsp_chan.request_id    = rid_ff;
   assign rsp_chan.body_length   = blen_ff;
   assign rsp_chan.verdict       = verdict_ff;
   assign rsp_chan.last_of_frame = last_ff;

endmodule

// ===== rtl/crc32_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// crc32_frame_deframer_top: length-prefixed frame deframer with crc-32 check
// Control registers, front hunter, work queue and back record builder.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while the work queue has room: the front
// hunter tags each word in the cycle it is accepted, the back end does one crc
// table step per header or body word, and a registered output stage lets a
// new word enter while a record waits to be taken. A body byte passes the work
// queue and the output register before it is valid on the record channel, and
// so does the verdict after the last checksum byte. The crc of the frame magic
// is kept precomputed in a register fed from the magic register. The byte side
// stalls only when the work queue is full, i.e. when the record side has held
// off long enough for QueueDepth words to pile up behind a waiting record.
module crc32_frame_deframer_top #(
   parameter int QueueDepth = cfd_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   cfd_req_if.sink     req_chan,
   cfd_rsp_if.source   rsp_chan
);

   logic [31:0] magic_ff;
   logic [7:0]  version_ff;
   logic [7:0]  req_type_ff;
   logic [7:0]  rsp_type_ff;
   logic [7:0]  hb_type_ff;
   logic [31:0] magic_crc_ff, magic_crc_in;

   cfd_pkg::front_cfg_type front_cfg;
   cfd_pkg::back_cfg_type  back_cfg;
   cfd_pkg::work_type      push_work;
   cfd_pkg::work_type      head;
   logic                   push;
   logic                   pop;
   logic                   q_not_full;
   logic                   q_not_empty;

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff    <= cfd_pkg::RST_FRAME_MAGIC;
         version_ff  <= cfd_pkg::RST_PROTO_VERSION;
         req_type_ff <= cfd_pkg::RST_REQUEST_TYPE;
         rsp_type_ff <= cfd_pkg::RST_RESPONSE_TYPE;
         hb_type_ff  <= cfd_pkg::RST_HEARTBEAT;
      end else if (csr_we) begin
         case (csr_index)
            cfd_pkg::CSR_FRAME_MAGIC:   magic_ff    <= csr_wdata;
            cfd_pkg::CSR_PROTO_VERSION: version_ff  <= csr_wdata[7:0];
            cfd_pkg::CSR_REQUEST_TYPE:  req_type_ff <= csr_wdata[7:0];
            cfd_pkg::CSR_RESPONSE_TYPE: rsp_type_ff <= csr_wdata[7:0];
            cfd_pkg::CSR_HEARTBEAT:     hb_type_ff  <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // crc over the four magic bytes, most significant first
   always_comb begin
      magic_crc_in = cfd_pkg::crc_byte(cfd_pkg::CRC_ONES, magic_ff[31:24]);
      magic_crc_in = cfd_pkg::crc_byte(magic_crc_in, magic_ff[23:16]);
      magic_crc_in = cfd_pkg::crc_byte(magic_crc_in, magic_ff[15:8]);
      magic_crc_in = cfd_pkg::crc_byte(magic_crc_in, magic_ff[7:0]);
   end

   always_ff @(posedge clock) begin
      magic_crc_ff <= magic_crc_in;
   end

   assign front_cfg = '{magic: magic_ff, version: version_ff};
   assign back_cfg  = '{magic_crc: magic_crc_ff, request_type: req_type_ff,
                        response_type: rsp_type_ff, heartbeat_type: hb_type_ff};

   cfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (front_cfg),
      .req_chan   (req_chan),
      .q_not_full (q_not_full),
      .push       (push),
      .push_work  (push_work)
   );

   cfd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_work (push_work),
      .pop       (pop),
      .not_full  (q_not_full),
      .not_empty (q_not_empty),
      .head      (head)
   );

   cfd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (back_cfg),
      .q_not_empty (q_not_empty),
      .head        (head),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule
